FILE: sv/bcj_pkg.sv
// shared types and constants of the byte copy jump core
// no dependencies; imported by the sequencer and the top level
`default_nettype none

package bcj_pkg;

    // default memory address width
    localparam int ADDR_BITS_DEFAULT = 16;

    // fetch sequence counter width and word offsets within one instruction or vector
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] SRC_DONE   = 4'd3;  // source address complete
    localparam logic [CNT_W-1:0] FETCH_LAST = 4'd5;  // last source/destination word
    localparam logic [CNT_W-1:0] JUMP_FIRST = 4'd6;  // first jump address word
    localparam logic [CNT_W-1:0] JUMP_LAST  = 4'd8;  // last jump address word
    localparam logic [CNT_W-1:0] VEC_LAST   = 4'd2;  // last program counter vector word

    // operation codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_EXEC  = 2'd2,
        OP_VEC   = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_READ_DATA,
        S_FETCH,
        S_SRC_RD,
        S_COPY_WR,
        S_LOAD,
        S_FINISH
    } state_t;

    // one result transfer
    typedef struct packed {
        logic       valid;
        logic [7:0] read_data;
        logic [15:0] pc_value;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/bcj_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module bcj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: sv/bcj_ctrl.sv
// sequencer of the byte copy jump core: operation decode, memory access
// sequence, address assembly, program counter and result register
// depends on bcj_pkg; drives the port of one bcj_ram instance
`default_nettype none

module bcj_ctrl import bcj_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire op_t                  op,
    input  wire logic [15:0]          address,
    input  wire logic [7:0]           write_data,
    input  wire logic [15:0]          vec_addr,
    output logic                      mem_we,
    output logic [ADDR_BITS-1:0]      mem_addr,
    output logic [7:0]                mem_wdata,
    input  wire logic [7:0]           mem_rdata,
    output res_t                      res
);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    op_t                    op_reg, op_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic [7:0]             wdata_reg, wdata_next;
    logic [ADDR_BITS-1:0]   base_reg, base_next;
    logic [ADDR_BITS-1:0]   src_reg, src_next;
    logic [ADDR_BITS-1:0]   dst_reg, dst_next;
    logic [23:0]            acc_reg, acc_next;
    logic                   acc_en_reg, acc_en_next;
    logic [ADDR_BITS-1:0]   pc_reg, pc_next;
    res_t                   res_reg, res_next;

    logic [23:0]            acc_word;
    logic [ADDR_BITS-1:0]   acc_addr;
    logic [CNT_W-1:0]       cnt_end;

    // big-endian address assembly, wrapped to the memory size
    assign acc_word = {acc_reg[15:0], mem_rdata};
    assign acc_addr = ADDR_BITS'(acc_word);
    assign cnt_end  = (op_reg == OP_VEC) ? VEC_LAST : JUMP_LAST;

    assign busy = (state_reg != S_IDLE);
    assign res  = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        OP_WRITE: state_next = S_WRITE;
                        OP_READ:  state_next = S_READ;
                        OP_EXEC:  state_next = S_FETCH;
                        OP_VEC:   state_next = S_LOAD;
                    endcase
                end
            end
            S_WRITE:     state_next = S_IDLE;
            S_READ:      state_next = S_READ_DATA;
            S_READ_DATA: state_next = S_IDLE;
            S_FETCH:
            begin
                if (cnt_reg == FETCH_LAST)
                begin
                    state_next = S_SRC_RD;
                end
            end
            S_SRC_RD:    state_next = S_COPY_WR;
            S_COPY_WR:   state_next = S_LOAD;
            S_LOAD:
            begin
                if (cnt_reg == cnt_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // memory access, datapath updates and result
    always_comb
    begin
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        wdata_next  = wdata_reg;
        base_next   = base_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        acc_next    = acc_en_reg ? acc_word : acc_reg;
        acc_en_next = 1'b0;
        pc_next     = pc_reg;
        res_next    = '0;
        mem_we      = 1'b0;
        mem_addr    = base_reg + ADDR_BITS'(cnt_reg);
        mem_wdata   = wdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    addr_next  = ADDR_BITS'(address);
                    wdata_next = write_data;
                    cnt_next   = '0;
                    base_next  = (op == OP_VEC) ? ADDR_BITS'(vec_addr) : pc_reg;
                end
            end
            S_WRITE:
            begin
                mem_we             = 1'b1;
                mem_addr           = addr_reg;
                res_next.valid     = 1'b1;
                res_next.pc_value  = 16'(pc_reg);
            end
            S_READ:
            begin
                mem_addr = addr_reg;
            end
            S_READ_DATA:
            begin
                res_next.valid     = 1'b1;
                res_next.read_data = mem_rdata;
                res_next.pc_value  = 16'(pc_reg);
            end
            S_FETCH:
            begin
                // source and destination address words
                acc_en_next = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == SRC_DONE)
                begin
                    src_next = acc_addr;
                end
            end
            S_SRC_RD:
            begin
                dst_next = acc_addr;
                mem_addr = src_reg;
            end
            S_COPY_WR:
            begin
                // copy lands before the jump words are fetched
                mem_we    = 1'b1;
                mem_addr  = dst_reg;
                mem_wdata = mem_rdata;
                cnt_next  = JUMP_FIRST;
            end
            S_LOAD:
            begin
                acc_en_next = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
            end
            S_FINISH:
            begin
                pc_next           = acc_addr;
                res_next.valid    = 1'b1;
                res_next.pc_value = 16'(acc_addr);
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            acc_en_reg <= 1'b0;
            pc_reg     <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            acc_en_reg <= acc_en_next;
            pc_reg     <= pc_next;
            res_reg    <= res_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        addr_reg  <= addr_next;
        wdata_reg <= wdata_next;
        base_reg  <= base_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        acc_reg   <= acc_next;
    end

endmodule

`default_nettype wire

FILE: sv/byte_copy_jump_core_top.sv
// top level of the byte copy jump core: configuration register, sequencer
// and main memory; depends on bcj_pkg, bcj_ram and bcj_ctrl
`default_nettype none

// Usage
// An operation is accepted at a rising edge with start high and busy low.
// opcode 0 writes write_data at address, 1 reads address, 2 executes one
// instruction at the program counter, 3 loads the program counter from the
// three big-endian words at the configured vector address.
// Each operation gives one result: done is high for exactly one cycle with
// read_data (zero unless a read) and pc_value (program counter afterwards).
// The receiver cannot stall; every result is taken in its done cycle.
// busy is high from the accepting edge through the last state of the
// operation; done is high in the first cycle with busy low again, and a new
// operation may be accepted in that same cycle.
// All memory accesses go to the single port of the main memory: an
// instruction takes six address fetches, one source read, one destination
// write and three jump fetches, then settles the program counter.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) is always
// ready and sets the vector address; write it only while idle.
// Reset clears the program counter, the vector address and the sequencer;
// memory contents are undefined until written.

module byte_copy_jump_core_top import bcj_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    output logic             done,
    output logic [7:0]       read_data,
    output logic [15:0]      pc_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    logic [15:0]          vec_addr_reg, vec_addr_next;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [7:0]           mem_wdata;
    logic [7:0]           mem_rdata;
    res_t                 res;

    // vector address register, written on a configuration transfer
    assign cfg_ready     = 1'b1;
    assign vec_addr_next = (cfg_valid && cfg_ready) ? cfg_data : vec_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_addr_reg <= '0;
        end
        else
        begin
            vec_addr_reg <= vec_addr_next;
        end
    end

    // sequencer
    bcj_ctrl #(
        .ADDR_BITS (ADDR_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op_t'(opcode)),
        .address    (address),
        .write_data (write_data),
        .vec_addr   (vec_addr_reg),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata),
        .res        (res)
    );

    // main memory
    bcj_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // result transfer
    assign done      = res.valid;
    assign read_data = res.read_data;
    assign pc_value  = res.pc_value;

endmodule

`default_nettype wire
